// ----- hw/rtl/sdcr_pkg.sv -----
// Shared types and constants for the segment descriptor clock refill block.
package sdcr_pkg;

    localparam int DEF_DESCRIPTOR_COUNT = 32;
    localparam int DEF_PAGE_SHIFT       = 12;

    localparam int REQ_W       = 2;
    localparam int ADDR_W      = 24;
    localparam int ASN_W       = 8;
    localparam int IDX_W       = 5;
    localparam int FIELD_W     = 16;
    localparam int FIELD_SHIFT = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_FAULT  = 2'd0,
        REQ_ACCESS = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic access;
        logic clear;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic stop;
        logic out_free;
        logic ptr_zero;
    } dp_status_t;

endpackage

// ----- hw/rtl/sdcr_ctrl.sv -----
// Controller state machine: request decode, clock scan sequencing and result commit.
module sdcr_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sdcr_pkg::REQ_W-1:0]   req_type,
    input  sdcr_pkg::dp_status_t         status,
    output sdcr_pkg::dp_cmd_t            cmd
);
    import sdcr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (req_type)
                        REQ_FAULT:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        REQ_ACCESS: cmd.access = 1'b1;
                        REQ_CLEAR:  cmd.clear  = 1'b1;
                        default:    ;  // drop unknown request
                    endcase
                end
            end
            ST_SCAN:
            begin
                // advance one descriptor per cycle until a victim is found
                cmd.scan = 1'b1;
                if (status.stop)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/sdcr_dp.sv -----
// Datapath: descriptor state, owner memory, address arithmetic and result register.
module sdcr_dp #(
    parameter int DESCRIPTOR_COUNT = sdcr_pkg::DEF_DESCRIPTOR_COUNT,
    parameter int PAGE_SHIFT       = sdcr_pkg::DEF_PAGE_SHIFT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sdcr_pkg::dp_cmd_t               cmd,
    output sdcr_pkg::dp_status_t            status,
    input  logic [sdcr_pkg::ADDR_W-1:0]     fault_address,
    input  logic [sdcr_pkg::ADDR_W-1:0]     segment_logical_base,
    input  logic [sdcr_pkg::ADDR_W-1:0]     segment_physical_start,
    input  logic [sdcr_pkg::ASN_W-1:0]      process_id,
    input  logic [sdcr_pkg::IDX_W-1:0]      accessed_descriptor,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [sdcr_pkg::IDX_W-1:0]      descriptor_index,
    output logic [sdcr_pkg::ASN_W-1:0]      address_space_number,
    output logic [sdcr_pkg::FIELD_W-1:0]    logical_base_field,
    output logic [sdcr_pkg::FIELD_W-1:0]    logical_mask_field,
    output logic [sdcr_pkg::FIELD_W-1:0]    physical_base_field,
    output logic [sdcr_pkg::ASN_W-1:0]      evicted_owner,
    output logic                            victim_was_enabled
);
    import sdcr_pkg::*;

    localparam int PTR_W = $clog2(DESCRIPTOR_COUNT);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DESCRIPTOR_COUNT - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [FIELD_W-1:0] PAGE_MASK =
        ~FIELD_W'((1 << (PAGE_SHIFT - FIELD_SHIFT)) - 1);

    logic [PTR_W-1:0]            ptr_reg;
    logic [PTR_W-1:0]            ptr_next;
    logic [DESCRIPTOR_COUNT-1:0] en_reg;
    logic [DESCRIPTOR_COUNT-1:0] en_next;
    logic [DESCRIPTOR_COUNT-1:0] used_reg;
    logic [DESCRIPTOR_COUNT-1:0] used_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    logic [ADDR_W-1:0]  fault_reg;
    logic [ADDR_W-1:0]  phys_reg;
    logic [ASN_W-1:0]   asn_reg;
    logic               was_on_reg;
    logic [ASN_W-1:0]   owner_rd_reg;
    logic [ASN_W-1:0]   owner_mem [DESCRIPTOR_COUNT];

    logic [IDX_W-1:0]   idx_out_reg;
    logic [ASN_W-1:0]   asn_out_reg;
    logic [FIELD_W-1:0] lbase_out_reg;
    logic [FIELD_W-1:0] pbase_out_reg;
    logic [ASN_W-1:0]   evict_out_reg;
    logic               was_on_out_reg;

    logic [PTR_W-1:0]   cand;
    logic               hot;

    // next slot wraps past the last descriptor back to 1, skipping the supervisor
    assign cand = (ptr_reg >= PTR_LAST) ? PTR_ONE : ptr_reg + PTR_ONE;
    assign hot  = en_reg[cand] & used_reg[cand];

    assign status.stop     = ~hot;
    assign status.out_free = ~out_valid_reg | out_ready;
    assign status.ptr_zero = (ptr_reg == '0);

    always_comb
    begin
        ptr_next       = ptr_reg;
        en_next        = en_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.access)
        begin
            for (int i = 0; i < DESCRIPTOR_COUNT; i++)
            begin
                if (int'(accessed_descriptor) == i)
                begin
                    used_next[i] = 1'b1;
                end
            end
        end
        if (cmd.clear)
        begin
            en_next     = '0;
            en_next[0]  = 1'b1;
            used_next[0] = 1'b0;
            ptr_next    = '0;
        end
        if (cmd.scan)
        begin
            ptr_next = cand;
            if (hot)
            begin
                used_next[cand] = 1'b0;
            end
        end
        if (cmd.commit)
        begin
            en_next[ptr_reg]   = 1'b1;
            used_next[ptr_reg] = 1'b0;
            out_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            en_reg        <= DESCRIPTOR_COUNT'(1);
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            en_reg        <= en_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fault_reg <= fault_address;
            asn_reg   <= process_id;
            phys_reg  <= fault_address - segment_logical_base + segment_physical_start;
        end
        // latch the victim's enable and its old owner as the scan stops
        if (cmd.scan && !hot)
        begin
            was_on_reg   <= en_reg[cand];
            owner_rd_reg <= owner_mem[cand];
        end
        if (cmd.commit)
        begin
            owner_mem[ptr_reg] <= asn_reg;
            idx_out_reg    <= IDX_W'(ptr_reg);
            asn_out_reg    <= asn_reg;
            lbase_out_reg  <= fault_reg[ADDR_W-1:FIELD_SHIFT] & PAGE_MASK;
            pbase_out_reg  <= phys_reg[ADDR_W-1:FIELD_SHIFT] & PAGE_MASK;
            evict_out_reg  <= was_on_reg ? owner_rd_reg : '0;
            was_on_out_reg <= was_on_reg;
        end
    end

    assign out_valid            = out_valid_reg;
    assign descriptor_index     = idx_out_reg;
    assign address_space_number = asn_out_reg;
    assign logical_base_field   = lbase_out_reg;
    assign logical_mask_field   = PAGE_MASK;
    assign physical_base_field  = pbase_out_reg;
    assign evicted_owner        = evict_out_reg;
    assign victim_was_enabled   = was_on_out_reg;

endmodule

// ----- hw/rtl/segment_descriptor_clock_refill.sv -----
// Segment descriptor refill with clock (second chance) victim choice.
// One request beat is taken at a time. Access and clear requests complete in the
// cycle they are accepted, and the block is ready again the next cycle. A page
// fault is captured, then the clock pointer visits k descriptors in the scan state
// (one per cycle through the enable/used bits, the last visit also reading
// the owner memory), between 1 and DESCRIPTOR_COUNT: one lap clears every used bit
// it passes, so the visit after it always stops. The commit state waits
// while an earlier result beat has not been taken. Results sit in an output
// register, so the next request is accepted while a result is pending.
module segment_descriptor_clock_refill #(
    parameter int DESCRIPTOR_COUNT = sdcr_pkg::DEF_DESCRIPTOR_COUNT,
    parameter int PAGE_SHIFT       = sdcr_pkg::DEF_PAGE_SHIFT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sdcr_pkg::REQ_W-1:0]      req_type,
    input  logic [sdcr_pkg::ADDR_W-1:0]     fault_address,
    input  logic [sdcr_pkg::ADDR_W-1:0]     segment_logical_base,
    input  logic [sdcr_pkg::ADDR_W-1:0]     segment_physical_start,
    input  logic [sdcr_pkg::ASN_W-1:0]      process_id,
    input  logic [sdcr_pkg::IDX_W-1:0]      accessed_descriptor,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sdcr_pkg::IDX_W-1:0]      descriptor_index,
    output logic [sdcr_pkg::ASN_W-1:0]      address_space_number,
    output logic [sdcr_pkg::FIELD_W-1:0]    logical_base_field,
    output logic [sdcr_pkg::FIELD_W-1:0]    logical_mask_field,
    output logic [sdcr_pkg::FIELD_W-1:0]    physical_base_field,
    output logic [sdcr_pkg::ASN_W-1:0]      evicted_owner,
    output logic                            victim_was_enabled
);
    import sdcr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sdcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    sdcr_dp #(
        .DESCRIPTOR_COUNT (DESCRIPTOR_COUNT),
        .PAGE_SHIFT       (PAGE_SHIFT)
    ) u_dp (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .status                 (status),
        .fault_address          (fault_address),
        .segment_logical_base   (segment_logical_base),
        .segment_physical_start (segment_physical_start),
        .process_id             (process_id),
        .accessed_descriptor    (accessed_descriptor),
        .out_ready              (out_ready),
        .out_valid              (out_valid),
        .descriptor_index       (descriptor_index),
        .address_space_number   (address_space_number),
        .logical_base_field     (logical_base_field),
        .logical_mask_field     (logical_mask_field),
        .physical_base_field    (physical_base_field),
        .evicted_owner          (evicted_owner),
        .victim_was_enabled     (victim_was_enabled)
    );

    // commit only overwrites the result register when it is free
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result committed over an untaken beat");

    // the supervisor descriptor is never loaded
    a_no_supervisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !status.ptr_zero)
        else $error("descriptor 0 chosen as victim");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed result not presented");

    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !(cmd.scan || cmd.commit))
        else $error("request accepted while a fault is in progress");

endmodule

// ----- bench/sdcr_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the segment descriptor refill block: predicts each refill and checks result beats.
module sdcr_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [sdcr_pkg::REQ_W-1:0]      req_type,
    input  logic [sdcr_pkg::ADDR_W-1:0]     fault_address,
    input  logic [sdcr_pkg::ADDR_W-1:0]     segment_logical_base,
    input  logic [sdcr_pkg::ADDR_W-1:0]     segment_physical_start,
    input  logic [sdcr_pkg::ASN_W-1:0]      process_id,
    input  logic [sdcr_pkg::IDX_W-1:0]      accessed_descriptor,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [sdcr_pkg::IDX_W-1:0]      descriptor_index,
    input  logic [sdcr_pkg::ASN_W-1:0]      address_space_number,
    input  logic [sdcr_pkg::FIELD_W-1:0]    logical_base_field,
    input  logic [sdcr_pkg::FIELD_W-1:0]    logical_mask_field,
    input  logic [sdcr_pkg::FIELD_W-1:0]    physical_base_field,
    input  logic [sdcr_pkg::ASN_W-1:0]      evicted_owner,
    input  logic                            victim_was_enabled,
    output int                              waiting_results,
    output int                              mismatches
);
    import sdcr_pkg::*;

    localparam int DESCRIPTORS = DEF_DESCRIPTOR_COUNT;
    localparam logic [FIELD_W-1:0] PAGE_MASK =
        16'hFFFF & ~((16'd1 << (DEF_PAGE_SHIFT - FIELD_SHIFT)) - 16'd1);

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [ASN_W-1:0]   asn;
        logic [FIELD_W-1:0] lbase;
        logic [FIELD_W-1:0] mask;
        logic [FIELD_W-1:0] pbase;
        logic [ASN_W-1:0]   evicted;
        logic               was_on;
    } refill_t;

    logic             slot_on    [DESCRIPTORS];
    logic             slot_used  [DESCRIPTORS];
    logic [ASN_W-1:0] slot_owner [DESCRIPTORS];
    logic [IDX_W-1:0] hand;
    refill_t          pending_refills[$];

    initial
    begin
        mismatches      = 0;
        waiting_results = 0;
    end

    // Drop every user descriptor; used bits survive, the supervisor slot is rebuilt.
    function automatic void wipe_user_slots();
        for (int i = 1; i < DESCRIPTORS; i++)
        begin
            slot_on[i]    = 1'b0;
            slot_owner[i] = '0;
        end
        slot_on[0]    = 1'b1;
        slot_used[0]  = 1'b0;
        slot_owner[0] = '0;
        hand          = '0;
    endfunction

    // Sweep the clock hand, giving used slots a second chance, then load the victim.
    function automatic refill_t choose_victim(input logic [ADDR_W-1:0] fault,
                                              input logic [ADDR_W-1:0] lbase,
                                              input logic [ADDR_W-1:0] pstart,
                                              input logic [ASN_W-1:0]  pid);
        refill_t           r;
        logic [ADDR_W-1:0] phys;
        logic              found;
        int                p;
        p     = int'(hand);
        found = 1'b0;
        for (int tries = 0; tries < 2 * DESCRIPTORS + 2 && !found; tries++)
        begin
            p = (p + 1 >= DESCRIPTORS) ? 1 : p + 1;
            if (slot_on[p] && slot_used[p])
                slot_used[p] = 1'b0;
            else
                found = 1'b1;
        end
        hand      = p[IDX_W-1:0];
        phys      = fault - lbase + pstart;
        r.index   = p[IDX_W-1:0];
        r.asn     = pid;
        r.lbase   = fault[ADDR_W-1:FIELD_SHIFT] & PAGE_MASK;
        r.mask    = PAGE_MASK;
        r.pbase   = phys[ADDR_W-1:FIELD_SHIFT] & PAGE_MASK;
        r.was_on  = slot_on[p];
        r.evicted = slot_on[p] ? slot_owner[p] : '0;
        slot_on[p]    = 1'b1;
        slot_used[p]  = 1'b0;
        slot_owner[p] = pid;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned expected,
                               input int unsigned actual);
        if (expected != actual)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        refill_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DESCRIPTORS; i++)
                slot_used[i] = 1'b0;
            wipe_user_slots();
            pending_refills.delete();
            waiting_results = 0;
        end
        else
        begin
            // Compare the result beat before queueing a fault taken on the same edge.
            if (out_valid && out_ready)
            begin
                if (pending_refills.size() == 0)
                begin
                    $error("result beat with no fault outstanding: descriptor_index %0d",
                           descriptor_index);
                    mismatches++;
                end
                else
                begin
                    want = pending_refills.pop_front();
                    check_field("descriptor_index", 32'(want.index),
                                32'(descriptor_index));
                    check_field("address_space_number", 32'(want.asn),
                                32'(address_space_number));
                    check_field("logical_base_field", 32'(want.lbase),
                                32'(logical_base_field));
                    check_field("logical_mask_field", 32'(want.mask),
                                32'(logical_mask_field));
                    check_field("physical_base_field", 32'(want.pbase),
                                32'(physical_base_field));
                    check_field("evicted_owner", 32'(want.evicted), 32'(evicted_owner));
                    check_field("victim_was_enabled", 32'(want.was_on),
                                32'(victim_was_enabled));
                end
            end
            if (in_valid && in_ready)
            begin
                case (req_type)
                    REQ_FAULT:
                        pending_refills.push_back(choose_victim(fault_address,
                            segment_logical_base, segment_physical_start, process_id));
                    REQ_ACCESS:
                        if (accessed_descriptor < DESCRIPTORS)
                            slot_used[accessed_descriptor] = 1'b1;
                    REQ_CLEAR:
                        wipe_user_slots();
                    default:
                        ;
                endcase
            end
            waiting_results = pending_refills.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top-level bench: drives request beats into the refill block, gates results, gives the verdict.
module testbench;
    import sdcr_pkg::*;

    localparam int TOTAL_ITEMS   = 1800;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 2 * DEF_DESCRIPTOR_COUNT + 8;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type;
    logic [ADDR_W-1:0]    fault_address;
    logic [ADDR_W-1:0]    segment_logical_base;
    logic [ADDR_W-1:0]    segment_physical_start;
    logic [ASN_W-1:0]     process_id;
    logic [IDX_W-1:0]     accessed_descriptor;
    logic                 out_valid;
    logic                 out_ready;
    logic [IDX_W-1:0]     descriptor_index;
    logic [ASN_W-1:0]     address_space_number;
    logic [FIELD_W-1:0]   logical_base_field;
    logic [FIELD_W-1:0]   logical_mask_field;
    logic [FIELD_W-1:0]   physical_base_field;
    logic [ASN_W-1:0]     evicted_owner;
    logic                 victim_was_enabled;

    int waiting_results;
    int mismatches;
    int idle_pct;
    int stall_pct;
    int sent_items;
    int cycle_count;

    segment_descriptor_clock_refill dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .req_type               (req_type),
        .fault_address          (fault_address),
        .segment_logical_base   (segment_logical_base),
        .segment_physical_start (segment_physical_start),
        .process_id             (process_id),
        .accessed_descriptor    (accessed_descriptor),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .descriptor_index       (descriptor_index),
        .address_space_number   (address_space_number),
        .logical_base_field     (logical_base_field),
        .logical_mask_field     (logical_mask_field),
        .physical_base_field    (physical_base_field),
        .evicted_owner          (evicted_owner),
        .victim_was_enabled     (victim_was_enabled)
    );

    sdcr_checker scoreboard (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .req_type               (req_type),
        .fault_address          (fault_address),
        .segment_logical_base   (segment_logical_base),
        .segment_physical_start (segment_physical_start),
        .process_id             (process_id),
        .accessed_descriptor    (accessed_descriptor),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .descriptor_index       (descriptor_index),
        .address_space_number   (address_space_number),
        .logical_base_field     (logical_base_field),
        .logical_mask_field     (logical_mask_field),
        .physical_base_field    (physical_base_field),
        .evicted_owner          (evicted_owner),
        .victim_was_enabled     (victim_was_enabled),
        .waiting_results        (waiting_results),
        .mismatches             (mismatches)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("segment_descriptor_clock_refill verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready = ($urandom_range(99) >= stall_pct);

    // Present one request beat and hold it until the block takes it.
    task automatic send_request(input logic [REQ_W-1:0]  kind,
                                input logic [ADDR_W-1:0] fault,
                                input logic [ADDR_W-1:0] lbase,
                                input logic [ADDR_W-1:0] pstart,
                                input logic [ASN_W-1:0]  pid,
                                input logic [IDX_W-1:0]  acc);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid               = 1'b1;
        req_type               = kind;
        fault_address          = fault;
        segment_logical_base   = lbase;
        segment_physical_start = pstart;
        process_id             = pid;
        accessed_descriptor    = acc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (kind != REQ_UNKNOWN)
            sent_items++;
    endtask

    // Mostly a segment base at or below the fault address; sometimes any base at all.
    task automatic send_random_fault();
        logic [ADDR_W-1:0] fault;
        logic [ADDR_W-1:0] lbase;
        logic [ADDR_W-1:0] pstart;
        logic [ASN_W-1:0]  pid;
        logic [IDX_W-1:0]  acc;
        fault  = ADDR_W'($urandom);
        pstart = ADDR_W'($urandom);
        pid    = ASN_W'($urandom);
        acc    = IDX_W'($urandom);
        if ($urandom_range(99) < 80)
            lbase = fault & ~ADDR_W'($urandom_range(0, 'hFFFF));
        else
            lbase = ADDR_W'($urandom);
        send_request(REQ_FAULT, fault, lbase, pstart, pid, acc);
    endtask

    task automatic send_random_beat();
        int pick;
        int start;
        int run;
        pick = int'($urandom_range(99));
        if (pick < 3)
        begin
            // Mark a run of descriptors used, then fault so the hand must pass them.
            start = int'($urandom_range(DEF_DESCRIPTOR_COUNT - 1));
            run   = int'($urandom_range(4, DEF_DESCRIPTOR_COUNT));
            for (int k = 0; k < run; k++)
                send_request(REQ_ACCESS, ADDR_W'($urandom), ADDR_W'($urandom),
                             ADDR_W'($urandom), ASN_W'($urandom),
                             IDX_W'((start + k) % DEF_DESCRIPTOR_COUNT));
            send_random_fault();
        end
        else if (pick < 55)
            send_random_fault();
        else if (pick < 93)
            send_request(REQ_ACCESS, ADDR_W'($urandom), ADDR_W'($urandom),
                         ADDR_W'($urandom), ASN_W'($urandom),
                         IDX_W'($urandom_range(DEF_DESCRIPTOR_COUNT - 1)));
        else if (pick < 94)
            send_request(REQ_CLEAR, ADDR_W'($urandom), ADDR_W'($urandom),
                         ADDR_W'($urandom), ASN_W'($urandom), IDX_W'($urandom));
        else
            send_request(REQ_UNKNOWN, ADDR_W'($urandom), ADDR_W'($urandom),
                         ADDR_W'($urandom), ASN_W'($urandom), IDX_W'($urandom));
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        in_valid               = 1'b0;
        req_type               = REQ_FAULT;
        fault_address          = '0;
        segment_logical_base   = '0;
        segment_physical_start = '0;
        process_id             = '0;
        accessed_descriptor    = '0;
        out_ready              = 1'b0;
        idle_pct               = 0;
        stall_pct              = 0;
        sent_items             = 0;
        cycle_count            = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Field extremes, wrapped physical arithmetic, access corners, unknown and clear.
        send_request(REQ_FAULT, 24'h000000, 24'h000000, 24'h000000, 8'h00, 5'd0);
        send_request(REQ_FAULT, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 8'hFF, 5'd31);
        send_request(REQ_FAULT, 24'h000100, 24'hFFFFFF, 24'h000000, 8'h80, 5'd0);
        send_request(REQ_ACCESS, 24'h0, 24'h0, 24'h0, 8'h0, 5'd0);
        send_request(REQ_ACCESS, 24'h0, 24'h0, 24'h0, 8'h0, 5'd31);
        send_request(REQ_ACCESS, 24'h0, 24'h0, 24'h0, 8'h0, 5'd20);
        send_request(REQ_ACCESS, 24'h0, 24'h0, 24'h0, 8'h0, 5'd1);
        send_request(REQ_FAULT, 24'h123456, 24'h120000, 24'hABC000, 8'h55, 5'd0);
        send_request(REQ_UNKNOWN, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 5'd31);
        send_request(REQ_CLEAR, 24'h0, 24'h0, 24'h0, 8'h0, 5'd0);
        send_request(REQ_FAULT, 24'h00FFFF, 24'h00F000, 24'h000FFF, 8'h01, 5'd0);
        send_request(REQ_ACCESS, 24'h0, 24'h0, 24'h0, 8'h0, 5'd1);
        send_request(REQ_FAULT, 24'hFFF000, 24'hFFF000, 24'h000000, 8'hFE, 5'd0);
        send_request(REQ_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 5'd31);
        send_request(REQ_FAULT, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 8'h7F, 5'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 58;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 58;
                end
                default:
                begin
                    idle_pct  = 15;
                    stall_pct = 15;
                end
            endcase
            while (sent_items < (phase + 1) * TOTAL_ITEMS / 4)
                send_random_beat();
            if (phase == 2)
            begin
                // Hold the request side until every outstanding refill has come back.
                @(negedge clk);
                in_valid = 1'b0;
                while (waiting_results != 0)
                    @(negedge clk);
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (waiting_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("segment_descriptor_clock_refill verification clean");
        else
            $display("segment_descriptor_clock_refill verification failed");
        $finish;
    end

endmodule
